### design/fixed_font_5x7_text_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 5x7 text rasterizer
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_FONT_5X7_TEXT_RASTERIZER_MACROS_SVH
`define FIXED_FONT_5X7_TEXT_RASTERIZER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define F57R_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("f57r port check failed");

// next-cycle implication, disabled while reset is asserted
`define F57R_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("f57r port check failed");

`endif

### design/f57r_pkg.sv
// ----------------------------------------------------------------------------
// f57r_pkg
// Types and codes shared by the text rasterizer front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package f57r_pkg;

  // request kinds carried on s_axis_tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BEGIN = 2'd1,
    REQ_DRAW  = 2'd2
  } req_e;

  // configuration register indexes
  localparam logic [2:0] CFG_LSB_TOP  = 3'd0;
  localparam logic [2:0] CFG_GAP      = 3'd1;
  localparam logic [2:0] CFG_FORE     = 3'd2;
  localparam logic [2:0] CFG_BACK_EN  = 3'd3;
  localparam logic [2:0] CFG_BACK     = 3'd4;
  localparam logic [2:0] CFG_BREAK    = 3'd5;

  // glyph geometry
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 7;
  localparam int unsigned LINE_PITCH  = 8;
  localparam int unsigned FIRST_CODE  = 32;

  // input beat layout
  localparam int unsigned S_TDATA_W   = 64;
  localparam int unsigned M_TDATA_W   = 48;

  // classified work for the back end
  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_BEGIN,
    CMD_BREAK,
    CMD_GLYPH,
    CMD_SKIP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [8:0]  addr;    // table index on loads, glyph base on draws
    logic [7:0]  data;    // font byte on loads
    logic [15:0] org_x;
    logic [15:0] org_y;
  } cmd_t;

  // live configuration seen by the back end
  typedef struct packed {
    logic        lsb_top;
    logic [7:0]  gap;
    logic [15:0] fore;
    logic        back_en;
    logic [15:0] back;
  } cfg_t;

endpackage

`default_nettype wire

### design/f57r_front.sv
// ----------------------------------------------------------------------------
// f57r_front
// Holds the configuration registers, takes input beats and turns each one
// into a back-end command (or drops it).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module f57r_front #(
  parameter int unsigned GLYPH_COUNT = 96,
  parameter int unsigned COLOR_BITS  = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [f57r_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic [1:0]                     s_axis_tuser,
  input  wire logic                           cfg_we_i,
  input  wire logic [2:0]                     cfg_idx_i,
  input  wire logic [15:0]                    cfg_data_i,
  input  wire logic                           q_full_i,
  output logic                                q_push_o,
  output f57r_pkg::cmd_t                      q_cmd_o,
  output f57r_pkg::cfg_t                      cfg_o
);
  import f57r_pkg::*;

  localparam int unsigned CW          = (COLOR_BITS < 16) ? COLOR_BITS : 16;
  localparam logic [9:0]  DEPTH_LIM   = 10'(GLYPH_COUNT * GLYPH_COLS);
  localparam logic [8:0]  CODE_END    = 9'(FIRST_CODE + GLYPH_COUNT);
  localparam logic [7:0]  CODE_FIRST  = 8'(FIRST_CODE);

  logic          lsb_top_q;
  logic [7:0]    gap_q;
  logic [CW-1:0] fore_q;
  logic          back_en_q;
  logic [CW-1:0] back_q;
  logic [7:0]    break_q;

  logic [8:0]    idx;
  logic [7:0]    tbyte;
  logic [15:0]   org_x;
  logic [15:0]   org_y;
  logic [7:0]    code;
  logic [6:0]    glyph;
  logic          accept;
  logic          keep;
  cmd_kind_e     kind;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsb_top_q <= 1'b0;
      gap_q     <= 8'd1;
      fore_q    <= '1;
      back_en_q <= 1'b0;
      back_q    <= '0;
      break_q   <= 8'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LSB_TOP: lsb_top_q <= cfg_data_i[0];
        CFG_GAP:     gap_q     <= cfg_data_i[7:0];
        CFG_FORE:    fore_q    <= cfg_data_i[CW-1:0];
        CFG_BACK_EN: back_en_q <= cfg_data_i[0];
        CFG_BACK:    back_q    <= cfg_data_i[CW-1:0];
        CFG_BREAK:   break_q   <= cfg_data_i[7:0];
        default:     ;
      endcase
    end
  end

  assign cfg_o.lsb_top = lsb_top_q;
  assign cfg_o.gap     = gap_q;
  assign cfg_o.fore    = 16'(fore_q);
  assign cfg_o.back_en = back_en_q;
  assign cfg_o.back    = 16'(back_q);

  // unpack the beat
  assign idx   = s_axis_tdata[8:0];
  assign tbyte = s_axis_tdata[16:9];
  assign org_x = s_axis_tdata[32:17];
  assign org_y = s_axis_tdata[48:33];
  assign code  = s_axis_tdata[56:49];
  assign glyph = 7'(code - CODE_FIRST);

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // classify: loads past the table and unknown kinds are dropped
  always_comb begin
    keep = 1'b0;
    kind = CMD_SKIP;
    case (s_axis_tuser)
      REQ_LOAD: begin
        keep = ({1'b0, idx} < DEPTH_LIM);
        kind = CMD_LOAD;
      end
      REQ_BEGIN: begin
        keep = 1'b1;
        kind = CMD_BEGIN;
      end
      REQ_DRAW: begin
        keep = 1'b1;
        if (code == break_q) begin
          kind = CMD_BREAK;
        end else if (code >= CODE_FIRST && {1'b0, code} < CODE_END) begin
          kind = CMD_GLYPH;
        end else begin
          kind = CMD_SKIP;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push_o      = accept && keep;
  assign q_cmd_o.kind  = kind;
  // glyph base is glyph * 5
  assign q_cmd_o.addr  = (kind == CMD_LOAD) ? idx
                         : (9'({glyph, 2'b00}) + 9'(glyph));
  assign q_cmd_o.data  = tbyte;
  assign q_cmd_o.org_x = org_x;
  assign q_cmd_o.org_y = org_y;

endmodule

`default_nettype wire

### design/f57r_queue.sv
// ----------------------------------------------------------------------------
// f57r_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module f57r_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire f57r_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output f57r_pkg::cmd_t       cmd_o
);
  import f57r_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  cmd_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == DEPTH);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

### design/f57r_back.sv
// ----------------------------------------------------------------------------
// f57r_back
// Executes commands: font memory writes, cursor updates and the pixel
// raster sequencer with its one-pixel hold and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module f57r_back #(
  parameter int unsigned GLYPH_COUNT = 96
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  wire f57r_pkg::cmd_t                 q_cmd_i,
  output logic                                q_pop_o,
  input  wire f57r_pkg::cfg_t                 cfg_i,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [f57r_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);
  import f57r_pkg::*;

  localparam int unsigned DEPTH    = GLYPH_COUNT * GLYPH_COLS;
  localparam int unsigned TAW      = $clog2(DEPTH);
  localparam logic [2:0]  ROW_LAST = 3'(GLYPH_ROWS - 1);
  localparam logic [2:0]  COL_LAST = 3'(GLYPH_COLS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DRAW,
    S_FLUSH
  } state_e;

  // font memory
  logic [7:0]     font_mem [DEPTH];
  logic [7:0]     rd_data_q;
  logic           rd_en;
  logic [TAW-1:0] rd_addr;
  logic           wr_en;

  state_e         state_q;
  logic [TAW-1:0] base_q;
  logic [2:0]     col_q;
  logic [2:0]     row_q;
  logic [15:0]    cx_q;
  logic [15:0]    cy_q;
  logic [15:0]    lx_q;

  logic           hold_valid_q;
  logic [15:0]    hold_x_q;
  logic [15:0]    hold_y_q;
  logic [15:0]    hold_c_q;

  logic           out_valid_q;
  logic [15:0]    out_x_q;
  logic [15:0]    out_y_q;
  logic [15:0]    out_c_q;
  logic           out_last_q;

  logic           out_free;
  logic           out_load;
  logic           bit_on;
  logic           emit;
  logic           advance;
  logic [15:0]    pix_x;
  logic [15:0]    pix_y;
  logic [15:0]    pix_c;
  logic [15:0]    cx_step;

  assign out_free = !out_valid_q || m_axis_tready;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign wr_en    = q_pop_o && (q_cmd_i.kind == CMD_LOAD);
  assign cx_step  = cx_q + 16'd5 + 16'(cfg_i.gap);

  // current pixel of the raster walk
  assign bit_on  = cfg_i.lsb_top ? rd_data_q[row_q] : rd_data_q[ROW_LAST - row_q];
  assign emit    = bit_on || cfg_i.back_en;
  assign pix_x   = cx_q + 16'(col_q);
  assign pix_y   = cy_q + 16'(row_q);
  assign pix_c   = bit_on ? cfg_i.fore : cfg_i.back;
  assign advance = !emit || !hold_valid_q || out_free;

  // held pixel moves to the output register
  assign out_load = ((state_q == S_DRAW) && advance && emit && hold_valid_q)
                    || ((state_q == S_FLUSH) && hold_valid_q && out_free);

  // next column is read as the walk leaves the bottom row
  assign rd_en   = (state_q == S_FETCH)
                   || ((state_q == S_DRAW) && advance && (row_q == ROW_LAST)
                       && (col_q != COL_LAST));
  assign rd_addr = base_q + ((state_q == S_FETCH) ? TAW'(0) : (TAW'(col_q) + TAW'(1)));

  always_ff @(posedge clk_i) begin
    if (wr_en) font_mem[q_cmd_i.addr[TAW-1:0]] <= q_cmd_i.data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= font_mem[rd_addr];
  end

  // sequencer, cursor state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_q       <= '0;
      col_q        <= 3'd0;
      row_q        <= 3'd0;
      cx_q         <= 16'd0;
      cy_q         <= 16'd0;
      lx_q         <= 16'd0;
      hold_valid_q <= 1'b0;
      hold_x_q     <= 16'd0;
      hold_y_q     <= 16'd0;
      hold_c_q     <= 16'd0;
      out_valid_q  <= 1'b0;
      out_x_q      <= 16'd0;
      out_y_q      <= 16'd0;
      out_c_q      <= 16'd0;
      out_last_q   <= 1'b0;
    end else begin
      // output beat loaded, or taken downstream
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            case (q_cmd_i.kind)
              CMD_BEGIN: begin
                lx_q <= q_cmd_i.org_x;
                cx_q <= q_cmd_i.org_x;
                cy_q <= q_cmd_i.org_y;
              end
              CMD_BREAK: begin
                cy_q <= cy_q + 16'(LINE_PITCH);
                cx_q <= lx_q;
              end
              CMD_SKIP: cx_q <= cx_step;
              CMD_GLYPH: begin
                base_q  <= q_cmd_i.addr[TAW-1:0];
                col_q   <= 3'd0;
                row_q   <= 3'd0;
                state_q <= S_FETCH;
              end
              default: ;
            endcase
          end
        end

        S_FETCH: state_q <= S_DRAW;

        S_DRAW: begin
          if (advance) begin
            if (emit) begin
              // previous held pixel is not the last one
              if (hold_valid_q) begin
                out_x_q     <= hold_x_q;
                out_y_q     <= hold_y_q;
                out_c_q     <= hold_c_q;
                out_last_q  <= 1'b0;
              end
              hold_valid_q <= 1'b1;
              hold_x_q     <= pix_x;
              hold_y_q     <= pix_y;
              hold_c_q     <= pix_c;
            end
            if (row_q == ROW_LAST) begin
              row_q <= 3'd0;
              if (col_q == COL_LAST) begin
                state_q <= S_FLUSH;
              end else begin
                col_q <= col_q + 3'd1;
              end
            end else begin
              row_q <= row_q + 3'd1;
            end
          end
        end

        S_FLUSH: begin
          if (!hold_valid_q) begin
            cx_q    <= cx_step;
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_x_q      <= hold_x_q;
            out_y_q      <= hold_y_q;
            out_c_q      <= hold_c_q;
            out_last_q   <= 1'b1;
            hold_valid_q <= 1'b0;
            cx_q         <= cx_step;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_c_q, out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### design/fixed_font_5x7_text_rasterizer.sv
// ----------------------------------------------------------------------------
// fixed_font_5x7_text_rasterizer
// 5x7 text rasterizer: font loads, text origin and per-character pixel stream.
// ----------------------------------------------------------------------------
// Input beats are classified by the front part and queued (two entries) for
// the back part. Font loads, begin items, line breaks and out-of-range codes
// are each handled in the back part as they are popped from the queue. A
// drawn character is popped, then its first column is read from font memory,
// then the sequencer walks each cell of the 5x7 raster (35), then it releases
// the final pixel with tlast. The single-pixel raster sequencer walks these
// steps in order; stalls on m_axis hold it. Pixels come out column by column,
// top row first. Unlit cells produce no beat unless background drawing is on.
// Reading a font entry never loaded gives an undefined pattern.
`timescale 1ns / 1ps
`default_nettype none

module fixed_font_5x7_text_rasterizer #(
  parameter int unsigned GLYPH_COUNT = 96,
  parameter int unsigned COLOR_BITS  = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave side
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // table_index[8:0], table_byte[16:9], origin_x[32:17], origin_y[48:33],
  // char_code[56:49], zero[63:57]
  input  wire logic [f57r_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                     s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], pixel_color[47:32]
  output logic [f57r_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // last_pixel
  output logic                                m_axis_tlast,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [2:0]                     cfg_idx_i,
  input  wire logic [15:0]                    cfg_data_i
);
  import f57r_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;
  cfg_t cfg;

  f57r_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .COLOR_BITS  (COLOR_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd),
    .cfg_o         (cfg)
  );

  f57r_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  f57r_back #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .cfg_i         (cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### design/f57r_checker.sv
// ----------------------------------------------------------------------------
// f57r_checker
// Port-level checks on the text rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_font_5x7_text_rasterizer_macros.svh"

module f57r_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic        m_axis_tlast
);

  // a stalled pixel beat keeps its payload
  `F57R_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // the queue only fills up right after an input beat was taken
  `F57R_ASSERT_IMP(a_ready_drop, clk_i, rst_ni, $fell(s_axis_tready), $past(s_axis_tvalid))

  // coming out of reset: empty queue, nothing on the output
  `F57R_ASSERT_IMP(a_reset_clean, clk_i, rst_ni, $rose(rst_ni), s_axis_tready && !m_axis_tvalid)

endmodule

bind fixed_font_5x7_text_rasterizer f57r_checker u_f57r_checker (.*);

`default_nettype wire
